// ===== rtl/nif_pkg.sv =====
// ---------------------------------------------------------------------------
// nif_pkg
// Shared types and constants for the NEC infrared frame decoder.
// ---------------------------------------------------------------------------
package nif_pkg;

  // Field widths
  localparam int LEN_W  = 17;
  localparam int CODE_W = 32;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 1;

  // Default capture capacity in pulses
  localparam int CAPTURE_DEPTH_DEF = 128;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT    = 1'd1;

  // Register reset values
  localparam logic [LEN_W-1:0] BIT_THRESHOLD_RST = 17'd1200;
  localparam logic [LEN_W-1:0] DROP_LIMIT_RST    = 17'd100000;

  // Timing windows in microseconds (open intervals)
  localparam logic [LEN_W-1:0] LEAD_MARK_LO  = 17'd8500;
  localparam logic [LEN_W-1:0] LEAD_MARK_HI  = 17'd9500;
  localparam logic [LEN_W-1:0] RPT_SPACE_LO  = 17'd2000;
  localparam logic [LEN_W-1:0] RPT_SPACE_HI  = 17'd2500;
  localparam logic [LEN_W-1:0] HDR_SPACE_LO  = 17'd4000;
  localparam logic [LEN_W-1:0] HDR_SPACE_HI  = 17'd5000;
  localparam logic [LEN_W-1:0] RPT_MARK_LO   = 17'd300;
  localparam logic [LEN_W-1:0] RPT_MARK_HI   = 17'd700;

  // Data spaces sit at odd positions FIRST_DATA_POS .. LAST_DATA_POS
  localparam int FIRST_DATA_POS = 3;
  localparam int LAST_DATA_POS  = FIRST_DATA_POS + 2 * (CODE_W - 1);
  localparam int BIT_IDX_W      = $clog2(CODE_W);

  // Frame status codes
  typedef enum logic [STAT_W-1:0] {
    ST_NONE    = 3'd0,
    ST_NOISE   = 3'd1,
    ST_REPEAT  = 3'd2,
    ST_BAD_HDR = 3'd3,
    ST_NEW     = 3'd4
  } frame_status_t;

  // Class of the leading space
  typedef enum logic [1:0] {
    SPACE_OTHER  = 2'd0,
    SPACE_REPEAT = 2'd1,
    SPACE_HEADER = 2'd2
  } space_kind_t;

  // Capture summary handed from the capture stage to the decoder
  typedef struct packed {
    logic              empty;      // no pulse stored
    logic              short_frm;  // fewer than four pulses
    logic              lead_mark_ok;
    space_kind_t       space_kind;
    logic              third_ok;
    logic [CODE_W-1:0] acc;
  } cap_sum_t;

  // Open-interval range check
  function automatic logic between(input logic [LEN_W-1:0] v,
                                   input logic [LEN_W-1:0] lo,
                                   input logic [LEN_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

// ===== rtl/nif_capture.sv =====
// ---------------------------------------------------------------------------
// nif_capture
// Running pulse capture: count, header range checks and data bit gathering.
// ---------------------------------------------------------------------------
module nif_capture #(
  parameter int CAPTURE_DEPTH = nif_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pulse_step,
  input  logic                      clear,
  input  logic [nif_pkg::LEN_W-1:0] pulse_len,
  input  logic [nif_pkg::LEN_W-1:0] bit_threshold,
  input  logic [nif_pkg::LEN_W-1:0] drop_limit,
  output nif_pkg::cap_sum_t         cap_sum
);
  import nif_pkg::*;

  localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);
  localparam int POS_W = (CNT_W > 7) ? CNT_W : 7;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mark_ok_r, mark_ok_nxt;
  space_kind_t       kind_r, kind_nxt;
  logic              third_r, third_nxt;
  logic [CODE_W-1:0] acc_r, acc_nxt;

  logic              store;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_off;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic              data_pos;

  // Store only short pulses while room is left
  assign store = pulse_step && (pulse_len < drop_limit) &&
                 (count_r < CNT_W'(CAPTURE_DEPTH));

  assign pos      = POS_W'(count_r);
  assign pos_off  = pos - POS_W'(FIRST_DATA_POS);
  assign bit_idx  = pos_off[BIT_IDX_W:1];
  assign data_pos = (pos >= POS_W'(FIRST_DATA_POS)) &&
                    (pos <= POS_W'(LAST_DATA_POS)) && pos[0];

  // Next capture state
  always_comb begin
    count_nxt   = count_r;
    mark_ok_nxt = mark_ok_r;
    kind_nxt    = kind_r;
    third_nxt   = third_r;
    acc_nxt     = acc_r;
    if (clear) begin
      count_nxt   = '0;
      mark_ok_nxt = 1'b0;
      kind_nxt    = SPACE_OTHER;
      third_nxt   = 1'b0;
      acc_nxt     = '0;
    end else if (store) begin
      count_nxt = count_r + 1'b1;
      if (pos == POS_W'(0)) begin
        mark_ok_nxt = between(pulse_len, LEAD_MARK_LO, LEAD_MARK_HI);
      end
      if (pos == POS_W'(1)) begin
        if (between(pulse_len, RPT_SPACE_LO, RPT_SPACE_HI)) begin
          kind_nxt = SPACE_REPEAT;
        end else if (between(pulse_len, HDR_SPACE_LO, HDR_SPACE_HI)) begin
          kind_nxt = SPACE_HEADER;
        end else begin
          kind_nxt = SPACE_OTHER;
        end
      end
      if (pos == POS_W'(2)) begin
        third_nxt = between(pulse_len, RPT_MARK_LO, RPT_MARK_HI);
      end
      if (data_pos && (pulse_len > bit_threshold)) begin
        acc_nxt[bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      mark_ok_r <= 1'b0;
      kind_r    <= SPACE_OTHER;
      third_r   <= 1'b0;
      acc_r     <= '0;
    end else begin
      count_r   <= count_nxt;
      mark_ok_r <= mark_ok_nxt;
      kind_r    <= kind_nxt;
      third_r   <= third_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // Summary for the decoder
  always_comb begin
    cap_sum.empty        = (count_r == '0);
    cap_sum.short_frm    = (POS_W'(count_r) < POS_W'(4));
    cap_sum.lead_mark_ok = mark_ok_r;
    cap_sum.space_kind   = kind_r;
    cap_sum.third_ok     = third_r;
    cap_sum.acc          = acc_r;
  end

endmodule

// ===== rtl/nif_decode.sv =====
// ---------------------------------------------------------------------------
// nif_decode
// End-of-frame classification, held code and repeat flag, result register.
// ---------------------------------------------------------------------------
module nif_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       eof_step,
  input  nif_pkg::cap_sum_t          cap_sum,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [nif_pkg::STAT_W-1:0] out_frame_status,
  output logic [nif_pkg::CODE_W-1:0] out_code_word,
  output logic                       out_repeat_flag
);
  import nif_pkg::*;

  logic              valid_r, valid_nxt;
  frame_status_t     status_r, status_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              rpt_r, rpt_nxt;
  logic [CODE_W-1:0] rev_acc;

  // Bit reversal is plain wiring
  always_comb begin
    for (int k = 0; k < CODE_W; k++) begin
      rev_acc[k] = cap_sum.acc[CODE_W-1-k];
    end
  end

  // Frame decision
  always_comb begin
    status_nxt = status_r;
    code_nxt   = code_r;
    rpt_nxt    = rpt_r;
    valid_nxt  = valid_r && !out_ready;
    if (eof_step) begin
      valid_nxt = 1'b1;
      if (cap_sum.empty) begin
        status_nxt = ST_NONE;
      end else if (cap_sum.short_frm) begin
        status_nxt = ST_NOISE;
      end else if (cap_sum.lead_mark_ok && cap_sum.space_kind == SPACE_REPEAT &&
                   cap_sum.third_ok) begin
        status_nxt = ST_REPEAT;
        rpt_nxt    = 1'b1;
      end else if (cap_sum.lead_mark_ok && cap_sum.space_kind == SPACE_HEADER) begin
        status_nxt = ST_NEW;
        code_nxt   = rev_acc;
        rpt_nxt    = 1'b0;
      end else begin
        status_nxt = ST_BAD_HDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      code_r  <= '0;
      rpt_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      code_r  <= code_nxt;
      rpt_r   <= rpt_nxt;
    end
  end

  // Status payload needs no reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // Held values change only when a new result is loaded
  assign out_valid        = valid_r;
  assign out_frame_status = status_r;
  assign out_code_word    = code_r;
  assign out_repeat_flag  = rpt_r;

endmodule

// ===== rtl/nec_ir_frame_decoder_core.sv =====
// ---------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// NEC infrared frame decoder fed with edge-to-edge pulse lengths.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per pulse (in_cmd = 0, length
// in in_pulse_length) or an end-of-frame word (in_cmd = 1). Pulse words
// produce no result; each end-of-frame word produces exactly one result word
// on the output channel (out_valid/out_ready): status, held code, repeat flag.
// Path: each word first passes the input register; the result of an
// end-of-frame word is presented the cycle after it leaves that register.
// Throughput: one word per cycle outside stalls, set by the single compare
// stage between the input register and the capture/result registers.
// Stall: while a result waits on out_ready, pulse words still flow; an
// end-of-frame word waits in the input register until the result register
// is free, and in_ready drops only then.
// Reset (rst_n low, synchronous): capture cleared, held code and repeat flag
// zero, thresholds back to 1200 us and 100000 us, both channels empty.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 bit threshold,
// 1 drop limit); write only while the block is idle.
// ---------------------------------------------------------------------------
module nec_ir_frame_decoder_core #(
  parameter int CAPTURE_DEPTH = nif_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [nif_pkg::LEN_W-1:0]     in_pulse_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nif_pkg::STAT_W-1:0]    out_frame_status,
  output logic [nif_pkg::CODE_W-1:0]    out_code_word,
  output logic                          out_repeat_flag,
  input  logic                          cfg_we,
  input  logic [nif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nif_pkg::LEN_W-1:0]     cfg_wdata
);
  import nif_pkg::*;

  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [LEN_W-1:0] s1_len_r;
  logic [LEN_W-1:0] thr_r;
  logic [LEN_W-1:0] drop_r;
  logic             s1_go;
  logic             pulse_step;
  logic             eof_step;
  cap_sum_t         cap_sum;

  // Input stage drains unless it holds an end of frame facing a full result
  assign s1_go      = s1_valid_r && (!s1_cmd_r || !out_valid || out_ready);
  assign in_ready   = !s1_valid_r || s1_go;
  assign pulse_step = s1_go && !s1_cmd_r;
  assign eof_step   = s1_go && s1_cmd_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_cmd;
      s1_len_r <= in_pulse_length;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= BIT_THRESHOLD_RST;
      drop_r <= DROP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_THRESHOLD: thr_r  <= cfg_wdata;
        REG_DROP_LIMIT:    drop_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nif_capture #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .pulse_step    (pulse_step),
    .clear         (eof_step),
    .pulse_len     (s1_len_r),
    .bit_threshold (thr_r),
    .drop_limit    (drop_r),
    .cap_sum       (cap_sum)
  );

  nif_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .eof_step         (eof_step),
    .cap_sum          (cap_sum),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_frame_status (out_frame_status),
    .out_code_word    (out_code_word),
    .out_repeat_flag  (out_repeat_flag)
  );

endmodule

// ===== rtl/nif_checker.sv =====
// ---------------------------------------------------------------------------
// nif_checker
// Port-level checks for the NEC infrared frame decoder.
// ---------------------------------------------------------------------------
module nif_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [nif_pkg::STAT_W-1:0] out_frame_status,
  input logic [nif_pkg::CODE_W-1:0] out_code_word,
  input logic                       out_repeat_flag
);
  import nif_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status) &&
    $stable(out_code_word) && $stable(out_repeat_flag))
    else $error("stalled result changed");

  // Reset empties the result channel
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Repeat status sets the flag, a new code clears it
  a_rpt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_REPEAT |-> out_repeat_flag)
    else $error("repeat frame without repeat flag");

  a_new_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_NEW |-> !out_repeat_flag)
    else $error("new code with repeat flag set");

  // Status is always a defined code
  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_status == ST_NONE || out_frame_status == ST_NOISE ||
    out_frame_status == ST_REPEAT || out_frame_status == ST_BAD_HDR ||
    out_frame_status == ST_NEW)
    else $error("undefined frame status");

endmodule

bind nec_ir_frame_decoder_core nif_checker u_nif_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_status (out_frame_status),
  .out_code_word    (out_code_word),
  .out_repeat_flag  (out_repeat_flag)
);
